/* rtl/assert_macros.svh */
// Assertion macros used by the checker file.
// No dependencies; the clock and reset are passed by the caller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, off while reset is high.
`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// Check a property on every rising edge, reset included.
`define ASSERT_ALL(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("assertion failed");

`endif

/* rtl/bns_pkg.sv */
// Shared constants, operation codes and types of the buzzer note sequencer.
// No dependencies.
`default_nettype none

package bns_pkg;

   localparam int QUEUE_DEPTH = 128;
   localparam int IDX_W       = $clog2(QUEUE_DEPTH);
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

   localparam int OP_W        = 3;
   localparam int HALF_W      = 16;
   localparam int BEATS_W     = 12;
   localparam int FRAC_W      = 8;
   localparam int TPB_W       = 24;
   localparam int ENTRY_W     = HALF_W + BEATS_W;
   localparam int PROD_W      = TPB_W + BEATS_W;
   localparam int SPAN_W      = PROD_W - FRAC_W;
   localparam int TOGGLE_W    = HALF_W + 1;
   localparam int ELAPSED_W   = SPAN_W + 1;
   localparam int OUT_W       = 8;

   localparam logic [TPB_W-1:0] TPB_RESET = 24'd1000000;

   localparam logic [OP_W-1:0] OP_TICK    = 3'd0;
   localparam logic [OP_W-1:0] OP_ENQUEUE = 3'd1;
   localparam logic [OP_W-1:0] OP_START   = 3'd2;
   localparam logic [OP_W-1:0] OP_PAUSE   = 3'd3;
   localparam logic [OP_W-1:0] OP_REWIND  = 3'd4;
   localparam logic [OP_W-1:0] OP_CLEAR   = 3'd5;

   typedef struct packed {
      logic               en;
      logic [IDX_W-1:0]   addr;
      logic [ENTRY_W-1:0] data;
   } ram_wr_type;

   typedef struct packed {
      logic             buzzer_level;
      logic             playing;
      logic [OUT_W-1:0] note_position;
      logic [OUT_W-1:0] note_count;
      logic             enqueue_dropped;
   } rsp_type;

endpackage

`default_nettype wire

/* rtl/bns_note_ram.sv */
// Note store: one write port, one registered read port with write forwarding.
// Depends on bns_pkg.
`default_nettype none

module bns_note_ram (
   input  wire logic                        clock,
   input  wire bns_pkg::ram_wr_type         wr,
   input  wire logic [bns_pkg::IDX_W-1:0]   rd_addr,
   output logic      [bns_pkg::ENTRY_W-1:0] rd_data_ff
);
   import bns_pkg::*;

   logic [ENTRY_W-1:0] mem_ff [QUEUE_DEPTH];

   // Write the note, read the addressed entry; pass a same-address write through
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[wr.addr] <= wr.data;
      end
      if (wr.en && (wr.addr == rd_addr)) begin
         rd_data_ff <= wr.data;
      end else begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

/* rtl/bns_span.sv */
// Note length unit: registers (ticks_per_beat * beats) >> 8.
// Depends on bns_pkg.
`default_nettype none

module bns_span (
   input  wire logic                       clock,
   input  wire logic [bns_pkg::TPB_W-1:0]   tpb,
   input  wire logic [bns_pkg::BEATS_W-1:0] beats,
   output logic      [bns_pkg::SPAN_W-1:0]  span_ff
);
   import bns_pkg::*;

   logic [PROD_W-1:0] prod;

   // Multiply and drop the fraction bits
   assign prod = PROD_W'(tpb) * PROD_W'(beats);

   always_ff @(posedge clock) begin
      span_ff <= prod[PROD_W-1:FRAC_W];
   end

endmodule

`default_nettype wire

/* rtl/bns_out_fifo.sv */
// Two-entry result buffer between the sequencer and the response channel.
// Depends on bns_pkg.
`default_nettype none

module bns_out_fifo (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire bns_pkg::rsp_type push_data,
   output logic                  full,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output bns_pkg::rsp_type      rsp_data
);
   import bns_pkg::*;

   rsp_type    entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       pop;

   assign full      = (count_ff == 2'd2);
   assign rsp_valid = (count_ff != 2'd0);
   assign rsp_data  = entry_ff[rd_ptr_ff];
   assign pop       = rsp_valid && rsp_ready;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Hold payload in the slot being filled
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

/* rtl/buzzer_note_sequencer.sv */
// Buzzer note sequencer: a queue of notes played as a square wave, one tick per request.
// Request channel req_* (operation, note fields), response channel rsp_*,
// register write channel csr_* carrying ticks_per_beat (always ready).
// Every accepted request yields exactly one response with the state after it:
// buzzer level, playing flag, note position, note count, enqueue dropped flag.
// The response is registered in the result buffer before it is presented.
// Throughput: one request per cycle, except that a tick is held off after the note
// position moves, after an enqueue writes the note at the current position, and
// after a register write, while the note store read and the note length
// multiplier (one register each) refill; so a note advance delays the next tick.
// Responses go into a two-entry buffer: while the receiver stalls, requests keep
// being accepted until both entries are full, and nothing is lost.
// Reset (synchronous, active high) empties the queue, stops playback, zeroes the
// timers and loads ticks_per_beat with 1000000. The note store itself is not
// cleared; only entries below the note count are ever used.
// Depends on bns_pkg, bns_note_ram, bns_span, bns_out_fifo.
`default_nettype none

module buzzer_note_sequencer (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire logic [bns_pkg::OP_W-1:0]    req_operation,
   input  wire logic [bns_pkg::HALF_W-1:0]  req_note_half_period,
   input  wire logic [bns_pkg::BEATS_W-1:0] req_note_beats,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output logic                             rsp_buzzer_level,
   output logic                             rsp_playing,
   output logic      [bns_pkg::OUT_W-1:0]   rsp_note_position,
   output logic      [bns_pkg::OUT_W-1:0]   rsp_note_count,
   output logic                             rsp_enqueue_dropped,
   input  wire logic                        csr_valid,
   output logic                             csr_ready,
   input  wire logic [bns_pkg::TPB_W-1:0]   csr_ticks_per_beat
);
   import bns_pkg::*;

   logic [CNT_W-1:0]     count_ff, count_in;
   logic [CNT_W-1:0]     idx_ff, idx_in;
   logic                 level_ff, level_in;
   logic                 run_ff, run_in;
   logic                 mid_ff, mid_in;
   logic [TOGGLE_W-1:0]  toggle_ff, toggle_in;
   logic [ELAPSED_W-1:0] elapsed_ff, elapsed_in;
   logic [TPB_W-1:0]     tpb_ff, tpb_in;
   logic                 stale_ff, stale_in;

   logic [ENTRY_W-1:0]   note;
   logic [HALF_W-1:0]    note_half;
   logic [BEATS_W-1:0]   note_beats;
   logic [SPAN_W-1:0]    span;
   logic [TOGGLE_W-1:0]  toggle_inc;
   logic [ELAPSED_W-1:0] elapsed_inc;
   logic [CNT_W-1:0]     idx_inc;

   logic                 fifo_full;
   logic                 req_fire;
   logic                 csr_fire;
   logic                 dropped;
   ram_wr_type           wr;
   rsp_type              result;
   rsp_type              rsp_data;

   assign csr_ready = 1'b1;
   assign csr_fire  = csr_valid && csr_ready;

   // Hold ticks while the note read or the length product is refilling
   assign req_ready = !fifo_full && !(stale_ff && (req_operation == OP_TICK));
   assign req_fire  = req_valid && req_ready;

   assign note_half   = note[ENTRY_W-1:BEATS_W];
   assign note_beats  = note[BEATS_W-1:0];
   assign toggle_inc  = toggle_ff + TOGGLE_W'(1);
   assign elapsed_inc = elapsed_ff + ELAPSED_W'(1);
   assign idx_inc     = idx_ff + CNT_W'(1);

   // Decode the request and update the playback state
   always_comb begin
      count_in   = count_ff;
      idx_in     = idx_ff;
      level_in   = level_ff;
      run_in     = run_ff;
      mid_in     = mid_ff;
      toggle_in  = toggle_ff;
      elapsed_in = elapsed_ff;
      dropped    = 1'b0;
      wr.en      = 1'b0;
      wr.addr    = count_ff[IDX_W-1:0];
      wr.data    = {req_note_half_period, req_note_beats};
      if (req_fire) begin
         unique case (req_operation)
            OP_TICK: begin
               if (run_ff) begin
                  if (idx_ff >= count_ff) begin
                     run_in = 1'b0;
                     mid_in = 1'b0;
                  end else begin
                     if (toggle_inc > TOGGLE_W'(note_half)) begin
                        level_in  = ~level_ff;
                        toggle_in = '0;
                     end else begin
                        toggle_in = toggle_inc;
                     end
                     if (elapsed_inc > ELAPSED_W'(span)) begin
                        idx_in     = idx_inc;
                        elapsed_in = '0;
                        if (idx_inc >= count_ff) begin
                           run_in = 1'b0;
                           mid_in = 1'b0;
                        end
                     end else begin
                        elapsed_in = elapsed_inc;
                     end
                  end
               end
            end
            OP_ENQUEUE: begin
               if (count_ff < CNT_W'(QUEUE_DEPTH)) begin
                  wr.en    = 1'b1;
                  count_in = count_ff + CNT_W'(1);
               end else begin
                  dropped = 1'b1;
               end
            end
            OP_START: begin
               if (idx_ff < count_ff) begin
                  run_in = 1'b1;
                  mid_in = 1'b1;
                  if (!mid_ff) begin
                     elapsed_in = '0;
                  end
               end
            end
            OP_PAUSE: begin
               if (run_ff) begin
                  mid_in = 1'b1;
               end
               run_in = 1'b0;
            end
            OP_REWIND: begin
               if (run_ff) begin
                  mid_in = 1'b1;
               end
               run_in     = 1'b0;
               idx_in     = '0;
               elapsed_in = '0;
            end
            OP_CLEAR: begin
               idx_in   = '0;
               count_in = '0;
            end
            default: begin
            end
         endcase
      end
   end

   // Take the register write
   assign tpb_in = csr_fire ? csr_ticks_per_beat : tpb_ff;

   // Mark the next cycle stale when the note read or its length must refill
   assign stale_in = (idx_in != idx_ff) || csr_fire
                     || (wr.en && (wr.addr == idx_in[IDX_W-1:0]));

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         idx_ff     <= '0;
         level_ff   <= 1'b0;
         run_ff     <= 1'b0;
         mid_ff     <= 1'b0;
         toggle_ff  <= '0;
         elapsed_ff <= '0;
         tpb_ff     <= TPB_RESET;
         stale_ff   <= 1'b1;
      end else begin
         count_ff   <= count_in;
         idx_ff     <= idx_in;
         level_ff   <= level_in;
         run_ff     <= run_in;
         mid_ff     <= mid_in;
         toggle_ff  <= toggle_in;
         elapsed_ff <= elapsed_in;
         tpb_ff     <= tpb_in;
         stale_ff   <= stale_in;
      end
   end

   // Read the note at the next position into the note store's read register
   bns_note_ram u_ram (
      .clock      (clock),
      .wr         (wr),
      .rd_addr    (idx_in[IDX_W-1:0]),
      .rd_data_ff (note)
   );

   bns_span u_span (
      .clock   (clock),
      .tpb     (tpb_ff),
      .beats   (note_beats),
      .span_ff (span)
   );

   // Build the response from the updated state
   always_comb begin
      result.buzzer_level    = level_in;
      result.playing         = run_in;
      result.note_position   = OUT_W'(idx_in);
      result.note_count      = OUT_W'(count_in);
      result.enqueue_dropped = dropped;
   end

   bns_out_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (req_fire),
      .push_data (result),
      .full      (fifo_full),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   assign rsp_buzzer_level    = rsp_data.buzzer_level;
   assign rsp_playing         = rsp_data.playing;
   assign rsp_note_position   = rsp_data.note_position;
   assign rsp_note_count      = rsp_data.note_count;
   assign rsp_enqueue_dropped = rsp_data.enqueue_dropped;

endmodule

`default_nettype wire

/* rtl/bns_checker.sv */
// Port-level checks of the buzzer note sequencer, bound to the top level.
// Depends on bns_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module bns_checker (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        req_valid,
   input wire logic                        req_ready,
   input wire logic [bns_pkg::OP_W-1:0]    req_operation,
   input wire logic [bns_pkg::HALF_W-1:0]  req_note_half_period,
   input wire logic [bns_pkg::BEATS_W-1:0] req_note_beats,
   input wire logic                        rsp_valid,
   input wire logic                        rsp_ready,
   input wire logic                        rsp_buzzer_level,
   input wire logic                        rsp_playing,
   input wire logic [bns_pkg::OUT_W-1:0]   rsp_note_position,
   input wire logic [bns_pkg::OUT_W-1:0]   rsp_note_count,
   input wire logic                        rsp_enqueue_dropped,
   input wire logic                        csr_valid,
   input wire logic                        csr_ready,
   input wire logic [bns_pkg::TPB_W-1:0]   csr_ticks_per_beat
);
   import bns_pkg::*;

   logic [2*OUT_W+2:0] rsp_payload;
   logic               rsp_stall;
   logic               queue_full;

   // Gather the response fields and the stall condition
   assign rsp_payload = {rsp_buzzer_level, rsp_playing, rsp_note_position, rsp_note_count,
                         rsp_enqueue_dropped};
   assign rsp_stall   = rsp_valid && !rsp_ready;
   assign queue_full  = (rsp_note_count == OUT_W'(QUEUE_DEPTH));

   // A stalled response holds
   `ASSERT_CLK(a_rsp_hold, clock, reset, rsp_stall |=> rsp_valid && $stable(rsp_payload))

   // An accepted request leaves a response waiting
   `ASSERT_CLK(a_req_to_rsp, clock, reset, req_valid && req_ready |=> rsp_valid)

   // A dropped enqueue reports a full queue
   `ASSERT_CLK(a_drop_full, clock, reset, rsp_valid && rsp_enqueue_dropped |-> queue_full)

   // Reset empties the response buffer
   `ASSERT_ALL(a_reset_empty, clock, reset |=> !rsp_valid)

endmodule

bind buzzer_note_sequencer bns_checker u_bns_checker (.*);

`default_nettype wire

/* bench/testbench.sv */
// Testbench of buzzer_note_sequencer: a directed table, then random songs under several tempos.
// Each response is checked by field against its table entry or a prediction from a private copy of the state.
// Depends on bns_pkg and buzzer_note_sequencer.

module testbench;
   import bns_pkg::*;

   // operation codes the block leaves unused
   localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
   localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

   localparam int RUN_LIMIT    = 200000;
   localparam int HOLD_CYCLES  = 300;
   localparam int PHASE_ITEMS  = 140;
   localparam int DRAIN_CYCLES = 6;
   localparam int TEMPO_PHASES = 6;

   localparam rsp_type IDLE_STATUS = '{1'b0, 1'b0, 8'd0, 8'd0, 1'b0};

   typedef enum {READY_ALWAYS, READY_COIN, READY_THIRDS, READY_MOSTLY} ready_mode_type;

   typedef struct packed {
      logic [OP_W-1:0]    op;
      logic [HALF_W-1:0]  half;
      logic [BEATS_W-1:0] beats;
      logic               typed;
      rsp_type            status;
   } directed_row_type;

   logic                clock                = 1'b0;
   logic                reset                = 1'b1;
   logic                req_valid            = 1'b0;
   logic                req_ready;
   logic [OP_W-1:0]     req_operation        = OP_TICK;
   logic [HALF_W-1:0]   req_note_half_period = '0;
   logic [BEATS_W-1:0]  req_note_beats       = '0;
   logic                rsp_valid;
   logic                rsp_ready            = 1'b0;
   logic                rsp_buzzer_level;
   logic                rsp_playing;
   logic [OUT_W-1:0]    rsp_note_position;
   logic [OUT_W-1:0]    rsp_note_count;
   logic                rsp_enqueue_dropped;
   logic                csr_valid            = 1'b0;
   logic                csr_ready;
   logic [TPB_W-1:0]    csr_ticks_per_beat   = TPB_RESET;

   // predicted sequencer state
   logic [ENTRY_W-1:0]  song_notes [QUEUE_DEPTH];
   logic [OUT_W-1:0]    song_count;
   logic [OUT_W-1:0]    song_index;
   logic                song_level;
   logic                song_running;
   logic                song_mid;
   logic [TOGGLE_W-1:0] toggle_ticks;
   logic [31:0]         note_ticks;
   logic [TPB_W-1:0]    tempo;

   rsp_type             status_queue [$];
   int                  sent_count    = 0;
   int                  checked_count = 0;
   int                  error_count   = 0;
   int                  burst_left    = 0;
   bit                  hold_off_req  = 1'b0;

   // reset status, start on an empty queue, unused codes, then a short song
   directed_row_type directed_rows [25] = '{
      '{OP_TICK,     16'h0000, 12'h000, 1'b1, IDLE_STATUS},
      '{OP_START,    16'hFFFF, 12'hFFF, 1'b1, IDLE_STATUS},
      '{OP_SPARE_LO, 16'hFFFF, 12'hFFF, 1'b1, IDLE_STATUS},
      '{OP_SPARE_HI, 16'h0000, 12'h000, 1'b1, IDLE_STATUS},
      '{OP_PAUSE,    16'h0000, 12'h000, 1'b1, IDLE_STATUS},
      '{OP_REWIND,   16'hFFFF, 12'hFFF, 1'b1, IDLE_STATUS},
      '{OP_ENQUEUE,  16'h0000, 12'h000, 1'b1, '{1'b0, 1'b0, 8'd0, 8'd1, 1'b0}},
      '{OP_ENQUEUE,  16'hFFFF, 12'hFFF, 1'b1, '{1'b0, 1'b0, 8'd0, 8'd2, 1'b0}},
      '{OP_ENQUEUE,  16'h0001, 12'h000, 1'b1, '{1'b0, 1'b0, 8'd0, 8'd3, 1'b0}},
      '{OP_START,    16'h0000, 12'h000, 1'b1, '{1'b0, 1'b1, 8'd0, 8'd3, 1'b0}},
      '{OP_TICK,     16'h0000, 12'h000, 1'b0, IDLE_STATUS},
      '{OP_TICK,     16'hFFFF, 12'hFFF, 1'b0, IDLE_STATUS},
      '{OP_PAUSE,    16'h0000, 12'h000, 1'b0, IDLE_STATUS},
      '{OP_TICK,     16'h0000, 12'h000, 1'b0, IDLE_STATUS},
      '{OP_START,    16'h0000, 12'h000, 1'b0, IDLE_STATUS},
      '{OP_TICK,     16'h0000, 12'h000, 1'b0, IDLE_STATUS},
      '{OP_REWIND,   16'h0000, 12'h000, 1'b0, IDLE_STATUS},
      '{OP_START,    16'h0000, 12'h000, 1'b0, IDLE_STATUS},
      '{OP_TICK,     16'h0000, 12'h000, 1'b0, IDLE_STATUS},
      '{OP_CLEAR,    16'hFFFF, 12'hFFF, 1'b0, IDLE_STATUS},
      '{OP_TICK,     16'h0000, 12'h000, 1'b0, IDLE_STATUS},
      '{OP_ENQUEUE,  16'h0002, 12'h000, 1'b0, IDLE_STATUS},
      '{OP_START,    16'h0000, 12'h000, 1'b0, IDLE_STATUS},
      '{OP_TICK,     16'h0000, 12'h000, 1'b0, IDLE_STATUS},
      '{OP_TICK,     16'h0000, 12'h000, 1'b0, IDLE_STATUS}
   };

   buzzer_note_sequencer dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_operation        (req_operation),
      .req_note_half_period (req_note_half_period),
      .req_note_beats       (req_note_beats),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_buzzer_level     (rsp_buzzer_level),
      .rsp_playing          (rsp_playing),
      .rsp_note_position    (rsp_note_position),
      .rsp_note_count       (rsp_note_count),
      .rsp_enqueue_dropped  (rsp_enqueue_dropped),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_ticks_per_beat   (csr_ticks_per_beat)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Stop playback at the end of the queue.
   function automatic void stop_song();
      song_running = 1'b0;
      song_mid     = 1'b0;
   endfunction

   // Pause: remember a song in progress, then stop the run flag.
   function automatic void hold_song();
      if (song_running) song_mid = 1'b1;
      song_running = 1'b0;
   endfunction

   // Advance both timers, toggle the buzzer, move to the next note.
   function automatic void advance_tick();
      logic [HALF_W-1:0]  half;
      logic [BEATS_W-1:0] beats;
      logic [PROD_W-1:0]  span;
      if (!song_running) return;
      if (song_index >= song_count) begin
         stop_song();
         return;
      end
      {half, beats} = song_notes[song_index[IDX_W-1:0]];
      if (toggle_ticks != '1) toggle_ticks++;
      if (note_ticks != '1) note_ticks++;
      if (toggle_ticks > {1'b0, half}) begin
         song_level   = ~song_level;
         toggle_ticks = '0;
      end
      span = (PROD_W'(tempo) * PROD_W'(beats)) >> FRAC_W;
      if (PROD_W'(note_ticks) > span) begin
         song_index++;
         note_ticks = '0;
         if (song_index >= song_count) stop_song();
      end
   endfunction

   // Apply one request to the predicted state and return the status after it.
   function automatic rsp_type predict_status(input logic [OP_W-1:0] op,
         input logic [HALF_W-1:0] half, input logic [BEATS_W-1:0] beats);
      rsp_type status;
      logic    dropped;
      dropped = 1'b0;
      case (op)
         OP_TICK: advance_tick();
         OP_ENQUEUE: begin
            if (song_count < OUT_W'(QUEUE_DEPTH)) begin
               song_notes[song_count[IDX_W-1:0]] = {half, beats};
               song_count++;
            end else begin
               dropped = 1'b1;
            end
         end
         OP_START: begin
            if (song_index < song_count) begin
               song_running = 1'b1;
               if (!song_mid) note_ticks = '0;
               song_mid = 1'b1;
            end
         end
         OP_PAUSE: hold_song();
         OP_REWIND: begin
            hold_song();
            song_index = '0;
            note_ticks = '0;
         end
         OP_CLEAR: begin
            song_index = '0;
            song_count = '0;
         end
         default: ;
      endcase
      status.buzzer_level    = song_level;
      status.playing         = song_running;
      status.note_position   = song_index;
      status.note_count      = song_count;
      status.enqueue_dropped = dropped;
      return status;
   endfunction

   task automatic report_error(input string what, input logic [31:0] got,
         input logic [31:0] want);
      $display("ERROR response %0d: %s got %0d expected %0d", checked_count, what, got, want);
      error_count++;
   endtask

   // Offer one request after an optional gap, hold it until accepted, predict.
   task automatic send_request(input logic [OP_W-1:0] op, input logic [HALF_W-1:0] half,
         input logic [BEATS_W-1:0] beats, input logic typed, input rsp_type typed_status);
      int      gap;
      rsp_type predicted;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid            <= 1'b1;
      req_operation        <= op;
      req_note_half_period <= half;
      req_note_beats       <= beats;
      do @(posedge clock); while (!req_ready);
      predicted = predict_status(op, half, beats);
      status_queue.push_back(typed ? typed_status : predicted);
      sent_count++;
   endtask

   task automatic send_op(input logic [OP_W-1:0] op, input logic [HALF_W-1:0] half,
         input logic [BEATS_W-1:0] beats);
      send_request(op, half, beats, 1'b0, IDLE_STATUS);
   endtask

   // Drop the request valid and wait for every predicted response.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (status_queue.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_tempo(input logic [TPB_W-1:0] value);
      wait_idle();
      csr_valid          <= 1'b1;
      csr_ticks_per_beat <= value;
      do @(posedge clock); while (!csr_ready);
      tempo = value;
      csr_valid <= 1'b0;
   endtask

   // Mostly short half periods so the buzzer toggles often.
   function automatic logic [HALF_W-1:0] pick_half();
      if ($urandom_range(0, 7) == 0) return HALF_W'($urandom);
      return HALF_W'($urandom_range(0, 6));
   endfunction

   // Keep notes a few ticks long at the current tempo, now and then any length.
   function automatic logic [BEATS_W-1:0] pick_beats();
      int unsigned limit;
      if (tempo == '0 || $urandom_range(0, 15) == 0) return BEATS_W'($urandom);
      limit = 2560 / 32'(tempo);
      if (limit > 4095) limit = 4095;
      return BEATS_W'($urandom_range(limit, 0));
   endfunction

   // One song: optional clear, a few notes, start, then mostly ticks.
   task automatic play_song(input int notes, input int steps);
      int pick;
      if ($urandom_range(0, 3) != 0) send_op(OP_CLEAR, HALF_W'($urandom), BEATS_W'($urandom));
      repeat (notes) send_op(OP_ENQUEUE, pick_half(), pick_beats());
      send_op(OP_START, HALF_W'($urandom), BEATS_W'($urandom));
      repeat (steps) begin
         pick = $urandom_range(0, 99);
         if (pick < 80)
            send_op(OP_TICK, HALF_W'($urandom), BEATS_W'($urandom));
         else if (pick < 85)
            send_op(OP_PAUSE, HALF_W'($urandom), BEATS_W'($urandom));
         else if (pick < 91)
            send_op(OP_START, HALF_W'($urandom), BEATS_W'($urandom));
         else if (pick < 93)
            send_op(OP_REWIND, HALF_W'($urandom), BEATS_W'($urandom));
         else if (pick < 95)
            send_op(OP_ENQUEUE, pick_half(), pick_beats());
         else if (pick < 96)
            send_op(OP_CLEAR, HALF_W'($urandom), BEATS_W'($urandom));
         else
            send_op(pick[0] ? OP_SPARE_HI : OP_SPARE_LO, HALF_W'($urandom),
                    BEATS_W'($urandom));
      end
   endtask

   // Compare each accepted response with the oldest prediction.
   always @(posedge clock) begin : check_status
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (status_queue.size() == 0) begin
            report_error("response with no request waiting", 32'd0, 32'd0);
         end else begin
            want = status_queue.pop_front();
            if (rsp_buzzer_level !== want.buzzer_level)
               report_error("buzzer_level", 32'(rsp_buzzer_level), 32'(want.buzzer_level));
            if (rsp_playing !== want.playing)
               report_error("playing", 32'(rsp_playing), 32'(want.playing));
            if (rsp_note_position !== want.note_position)
               report_error("note_position", 32'(rsp_note_position),
                            32'(want.note_position));
            if (rsp_note_count !== want.note_count)
               report_error("note_count", 32'(rsp_note_count), 32'(want.note_count));
            if (rsp_enqueue_dropped !== want.enqueue_dropped)
               report_error("enqueue_dropped", 32'(rsp_enqueue_dropped),
                            32'(want.enqueue_dropped));
         end
         checked_count++;
      end
   end

   // Receiver: stall in patterns, and hold off for a long stretch on request.
   initial begin : receiver
      ready_mode_type mode;
      int             mode_left;
      int             hold_count;
      int             third;
      mode      = READY_ALWAYS;
      mode_left = 0;
      third     = 0;
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            rsp_ready <= 1'b0;
            for (hold_count = 0; hold_count < HOLD_CYCLES; hold_count++) @(posedge clock);
         end
         if (mode_left == 0) begin
            mode      = ready_mode_type'($urandom_range(0, 3));
            mode_left = $urandom_range(20, 120);
         end
         mode_left--;
         third = (third + 1) % 3;
         case (mode)
            READY_ALWAYS: rsp_ready <= 1'b1;
            READY_COIN:   rsp_ready <= 1'($urandom_range(0, 1));
            READY_THIRDS: rsp_ready <= (third == 0);
            default:      rsp_ready <= ($urandom_range(0, 4) != 0);
         endcase
      end
   end

   // End the run if it takes far longer than the slowest correct run.
   initial begin : watchdog
      int unsigned cycle_count;
      cycle_count = 0;
      while (cycle_count < RUN_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("ERROR run limit of %0d cycles reached", RUN_LIMIT);
      $display("Simulation FAILED");
      $finish;
   end

   initial begin : stimulus
      logic [TPB_W-1:0] tempo_plan [TEMPO_PHASES];
      int               phase_start;
      tempo_plan = '{24'd256, 24'd1, 24'd0, 24'hFFFFFF,
                     TPB_W'($urandom_range(2, 2047)), TPB_W'($urandom_range(1, 24'hFFFFFF))};

      // hold reset, then clear the predicted state to match
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      song_count   = '0;
      song_index   = '0;
      song_level   = 1'b0;
      song_running = 1'b0;
      song_mid     = 1'b0;
      toggle_ticks = '0;
      note_ticks   = '0;
      tempo        = TPB_RESET;

      foreach (directed_rows[i])
         send_request(directed_rows[i].op, directed_rows[i].half, directed_rows[i].beats,
                      directed_rows[i].typed, directed_rows[i].status);

      for (int p = 0; p < TEMPO_PHASES; p++) begin
         write_tempo(tempo_plan[p]);
         phase_start = sent_count;
         // stall the receiver long enough that the response buffer fills
         if (p == 1) hold_off_req = 1'b1;
         // fill the queue past full and play every note to the end
         if (tempo == '0) begin
            send_op(OP_CLEAR, HALF_W'($urandom), BEATS_W'($urandom));
            repeat (QUEUE_DEPTH + 2) send_op(OP_ENQUEUE, pick_half(), pick_beats());
            send_op(OP_START, HALF_W'($urandom), BEATS_W'($urandom));
            repeat (QUEUE_DEPTH + 2) send_op(OP_TICK, HALF_W'($urandom), BEATS_W'($urandom));
         end
         while (sent_count - phase_start < PHASE_ITEMS)
            play_song($urandom_range(0, 6), $urandom_range(10, 70));
      end

      wait_idle();
      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
